FILE: sv/bbsf_pkg.sv
// Shared types and constants for the bounded byte stream FIFO.
`default_nettype none

package bbsf_pkg;

  // Action codes as they arrive on the input item
  typedef enum logic [2:0] {
    ACT_WRITE = 3'd0,
    ACT_END   = 3'd1,
    ACT_PEEK  = 3'd2,
    ACT_POP   = 3'd3,
    ACT_READ  = 3'd4
  } action_e;

  // Decoded operation handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_END,
    OP_PEEK,
    OP_POP,
    OP_READ,
    OP_NOP
  } op_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_STAT
  } state_e;

  localparam int unsigned CAP_W    = 11;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned TOTAL_W  = 48;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // Result queue depth and its level width
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_LVL_W = 3;

  typedef struct packed {
    logic [2:0]       action;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         byte_out;
    logic               byte_valid;
    logic               last_of_run;
    logic               write_accepted;
    logic               error_flag;
    logic [CAP_W-1:0]   buffered_count;
    logic [TOTAL_W-1:0] total_written;
    logic [TOTAL_W-1:0] total_read;
    logic               ended_flag;
    logic               end_of_stream;
  } out_item_t;

  typedef struct packed {
    op_e              op;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/bbsf_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module bbsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/bbsf_front.sv
// Front end: accepts input items, decodes the action, queues commands.
`default_nettype none

module bbsf_front #(
  parameter int unsigned MAX_LENGTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire bbsf_pkg::in_item_t in_item_i,
  output logic                   cmd_valid_o,
  output bbsf_pkg::cmd_t         cmd_o,
  input  wire logic              cmd_pop_i
);

  localparam logic [bbsf_pkg::LEN_W-1:0] MaxLen = bbsf_pkg::LEN_W'(MAX_LENGTH);

  bbsf_pkg::cmd_t cmd_q [2];
  bbsf_pkg::cmd_t dec;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = cmd_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Decode the action and saturate the length
  always_comb begin
    dec.data = in_item_i.data_byte;
    dec.len  = (in_item_i.length > MaxLen) ? MaxLen : in_item_i.length;
    unique case (bbsf_pkg::action_e'(in_item_i.action))
      bbsf_pkg::ACT_WRITE: dec.op = bbsf_pkg::OP_WRITE;
      bbsf_pkg::ACT_END:   dec.op = bbsf_pkg::OP_END;
      bbsf_pkg::ACT_PEEK:  dec.op = bbsf_pkg::OP_PEEK;
      bbsf_pkg::ACT_POP:   dec.op = bbsf_pkg::OP_POP;
      bbsf_pkg::ACT_READ:  dec.op = bbsf_pkg::OP_READ;
      default:             dec.op = bbsf_pkg::OP_NOP;
    endcase
  end

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the decoded command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      cmd_q[wr_ptr_q] <= dec;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bbsf_rq.sv
// Result queue: holds finished results until the consumer pops them.
`default_nettype none

module bbsf_rq (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  input  wire bbsf_pkg::out_item_t              item_i,
  input  wire logic                             pop,
  output logic                                  empty,
  output bbsf_pkg::out_item_t                   out_item_o,
  output logic [bbsf_pkg::RQ_LVL_W-1:0]         level_o
);

  localparam int unsigned PW = $clog2(bbsf_pkg::RQ_DEPTH);

  bbsf_pkg::out_item_t              ent_q [bbsf_pkg::RQ_DEPTH];
  logic [PW-1:0]                    wr_ptr_q, rd_ptr_q;
  logic [bbsf_pkg::RQ_LVL_W-1:0]    cnt_q, cnt_d;
  logic                             do_pop;

  assign empty      = (cnt_q == '0);
  assign out_item_o = ent_q[rd_ptr_q];
  assign level_o    = cnt_q;
  assign do_pop     = pop && !empty;

  always_comb begin
    cnt_d = cnt_q + bbsf_pkg::RQ_LVL_W'(push_i) - bbsf_pkg::RQ_LVL_W'(do_pop);
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Store a result
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

  // The back end only pushes against reserved space
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < bbsf_pkg::RQ_LVL_W'(bbsf_pkg::RQ_DEPTH)) || do_pop)
    else $error("result pushed into full queue");

endmodule

`default_nettype wire

FILE: sv/bbsf_back.sv
// Back end: executes commands on the byte store and builds result items.
`default_nettype none

module bbsf_back #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [bbsf_pkg::CAP_W-1:0]        cap_i,
  input  wire logic                              cmd_valid_i,
  input  wire bbsf_pkg::cmd_t                    cmd_i,
  output logic                                   cmd_pop_o,
  input  wire logic [bbsf_pkg::RQ_LVL_W-1:0]     rq_level_i,
  output logic                                   rq_push_o,
  output bbsf_pkg::out_item_t                    rq_item_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned MW = (CW > bbsf_pkg::CAP_W) ? CW : bbsf_pkg::CAP_W;
  localparam int unsigned SW = ((AW > bbsf_pkg::LEN_W) ? AW : bbsf_pkg::LEN_W) + 1;
  localparam int unsigned LW = bbsf_pkg::LEN_W;
  localparam int unsigned TW = bbsf_pkg::TOTAL_W;

  // Move a pointer forward by n places around the store
  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [LW-1:0] n);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(n);
    if (s >= SW'(STORE_DEPTH)) begin
      s = s - SW'(STORE_DEPTH);
    end
    return AW'(s);
  endfunction

  bbsf_pkg::state_e state_q, state_d;

  // Stream status
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] occ_q, occ_d;
  logic [TW-1:0] wtot_q, wtot_d;
  logic [TW-1:0] rtot_q, rtot_d;
  logic          done_q, done_d;
  logic          err_q, err_d;
  logic          acc_q, acc_d;

  // Emission sequencer
  logic [AW-1:0] rd_ptr_q;
  logic [LW-1:0] cnt_q;
  logic          pend_q, pend_last_q;

  logic          take, issue, stat_push, credit;
  logic [MW-1:0] occ_x, len_x;
  logic          long_req, room;
  logic [LW-1:0] n_min, nbytes;
  logic          we;
  logic [7:0]    rdata;

  assign credit = ({1'b0, rq_level_i} + {{bbsf_pkg::RQ_LVL_W{1'b0}}, pend_q})
                  < (bbsf_pkg::RQ_LVL_W + 1)'(bbsf_pkg::RQ_DEPTH);

  // Execute the command taken this cycle
  always_comb begin
    occ_x    = MW'(occ_q);
    len_x    = MW'(cmd_i.len);
    long_req = len_x > occ_x;
    n_min    = long_req ? LW'(occ_x) : cmd_i.len;
    room     = (occ_x < MW'(cap_i)) && (occ_x < MW'(STORE_DEPTH));
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    wtot_d   = wtot_q;
    rtot_d   = rtot_q;
    done_d   = done_q;
    err_d    = err_q;
    acc_d    = acc_q;
    we       = 1'b0;
    nbytes   = '0;
    if (take) begin
      acc_d = 1'b0;
      unique case (cmd_i.op)
        bbsf_pkg::OP_WRITE: begin
          if (room) begin
            we     = 1'b1;
            tail_d = ptr_add(tail_q, LW'(1));
            occ_d  = occ_q + 1'b1;
            wtot_d = wtot_q + 1'b1;
            acc_d  = 1'b1;
          end
        end
        bbsf_pkg::OP_END: begin
          done_d = 1'b1;
        end
        bbsf_pkg::OP_PEEK: begin
          nbytes = n_min;
        end
        bbsf_pkg::OP_POP: begin
          err_d  = err_q | long_req;
          head_d = ptr_add(head_q, n_min);
          occ_d  = occ_q - CW'(n_min);
          rtot_d = rtot_q + TW'(n_min);
        end
        bbsf_pkg::OP_READ: begin
          if (long_req) begin
            err_d = 1'b1;
          end else begin
            nbytes = cmd_i.len;
            head_d = ptr_add(head_q, cmd_i.len);
            occ_d  = occ_q - CW'(cmd_i.len);
            rtot_d = rtot_q + TW'(cmd_i.len);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbsf_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (nbytes != '0) ? bbsf_pkg::ST_EMIT : bbsf_pkg::ST_STAT;
        end
      end
      bbsf_pkg::ST_EMIT: begin
        if (credit && cnt_q == LW'(1)) begin
          state_d = bbsf_pkg::ST_IDLE;
        end
      end
      bbsf_pkg::ST_STAT: begin
        if (credit) begin
          state_d = bbsf_pkg::ST_IDLE;
        end
      end
      default: state_d = bbsf_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    take      = 1'b0;
    issue     = 1'b0;
    stat_push = 1'b0;
    unique case (state_q)
      bbsf_pkg::ST_IDLE: take      = cmd_valid_i;
      bbsf_pkg::ST_EMIT: issue     = credit;
      bbsf_pkg::ST_STAT: stat_push = credit;
      default: begin
      end
    endcase
  end

  assign cmd_pop_o = take;

  // Build the result from the status left by the current item
  always_comb begin
    rq_push_o                = pend_q || stat_push;
    rq_item_o.byte_out       = pend_q ? rdata : 8'd0;
    rq_item_o.byte_valid     = pend_q;
    rq_item_o.last_of_run    = pend_q ? pend_last_q : 1'b1;
    rq_item_o.write_accepted = pend_q ? 1'b0 : acc_q;
    rq_item_o.error_flag     = err_q;
    rq_item_o.buffered_count = bbsf_pkg::CAP_W'(occ_q);
    rq_item_o.total_written  = wtot_q;
    rq_item_o.total_read     = rtot_q;
    rq_item_o.ended_flag     = done_q;
    rq_item_o.end_of_stream  = done_q && (occ_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbsf_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      wtot_q      <= '0;
      rtot_q      <= '0;
      done_q      <= 1'b0;
      err_q       <= 1'b0;
      acc_q       <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      wtot_q      <= wtot_d;
      rtot_q      <= rtot_d;
      done_q      <= done_d;
      err_q       <= err_d;
      acc_q       <= acc_d;
      pend_q      <= issue;
      pend_last_q <= issue && (cnt_q == LW'(1));
      if (take) begin
        cnt_q <= nbytes;
      end else if (issue) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Walk the read pointer over the bytes to emit
  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_ptr_q <= head_q;
    end else if (issue) begin
      rd_ptr_q <= ptr_add(rd_ptr_q, LW'(1));
    end
  end

  bbsf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (cmd_i.data),
    .re_i    (issue),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(STORE_DEPTH))
    else $error("occupancy above store depth");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bbsf_pkg::ST_EMIT) |-> (cnt_q != '0))
    else $error("emitting with no bytes left");

  a_one_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && stat_push))
    else $error("byte and status result pushed together");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && pend_last_q) |-> (state_q != bbsf_pkg::ST_EMIT))
    else $error("sequencer still emitting after last byte");

endmodule

`default_nettype wire

FILE: sv/bounded_byte_stream_fifo_core.sv
// Top level of the bounded byte stream FIFO.
//
//  channel   handshake              payload
//  input     push / full            in_item_i  (action, data_byte, length)
//  result    empty / pop            out_item_o (byte and status per result)
//  config    cfg_valid_i / ready    cfg_data_i (capacity_limit)
//
// A write, end, pop, failed read, unknown action or zero-byte peek or read is
// executed in the back end's idle state, then queues its status result. A peek
// or read of N bytes emits one byte per cycle, while the result queue has room,
// from the single read port of the byte store. Reset clears all status at once;
// the byte store needs no clearing pass. A full result queue stalls the back
// end, and the command queue in front keeps taking input until it fills.
`default_nettype none

module bounded_byte_stream_fifo_core #(
  parameter int unsigned STORE_DEPTH = 1024,
  parameter int unsigned MAX_LENGTH  = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire bbsf_pkg::in_item_t          in_item_i,
  output logic                             empty,
  input  wire logic                        pop,
  output bbsf_pkg::out_item_t              out_item_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bbsf_pkg::CAP_W-1:0]  cfg_data_i
);

  logic [bbsf_pkg::CAP_W-1:0]    cap_q;
  logic                          cmd_valid, cmd_pop;
  bbsf_pkg::cmd_t                cmd;
  logic                          rq_push;
  bbsf_pkg::out_item_t           rq_item;
  logic [bbsf_pkg::RQ_LVL_W-1:0] rq_level;

  assign cfg_ready_o = 1'b1;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= bbsf_pkg::CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  bbsf_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bbsf_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rq_level_i  (rq_level),
    .rq_push_o   (rq_push),
    .rq_item_o   (rq_item)
  );

  bbsf_rq u_rq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (rq_push),
    .item_i     (rq_item),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item_o),
    .level_o    (rq_level)
  );

endmodule

`default_nettype wire

FILE: test/tb_bounded_byte_stream_fifo_core.sv
// Self-checking testbench for the bounded byte stream FIFO core.
`timescale 1ns / 100ps

module tb_bounded_byte_stream_fifo_core;
  import bbsf_pkg::*;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned MAX_LENGTH  = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 400;

  // Action codes the block treats as no operation
  localparam logic [2:0] ACT_RSVD_LO = 3'd5;
  localparam logic [2:0] ACT_RSVD_HI = 3'd7;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } directed_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             push        = 1'b0;
  logic             full;
  in_item_t         in_item_i   = '0;
  logic             empty;
  logic             pop         = 1'b0;
  out_item_t        out_item_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i  = '0;

  bounded_byte_stream_fifo_core #(
    .STORE_DEPTH(STORE_DEPTH),
    .MAX_LENGTH (MAX_LENGTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Mirror of the FIFO state
  logic [7:0]         fifo_bytes [STORE_DEPTH];
  logic [9:0]         head_idx        = '0;
  logic [9:0]         tail_idx        = '0;
  logic [CAP_W-1:0]   fill_level      = '0;
  logic [TOTAL_W-1:0] bytes_in_total  = '0;
  logic [TOTAL_W-1:0] bytes_out_total = '0;
  logic               stream_closed   = 1'b0;
  logic               error_seen      = 1'b0;
  logic [CAP_W-1:0]   capacity_reg    = CAP_RESET;

  out_item_t     pending_results [$];
  directed_row_t directed_rows [$];
  int            mismatches      = 0;
  int unsigned   cycle_count     = 0;
  int            send_idle_pct   = 0;
  int            recv_idle_pct   = 0;
  bit            long_hold_armed = 1'b0;
  bit            long_hold_taken = 1'b0;
  int            hold_left       = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Apply one item to the mirror and queue the results it causes
  function automatic void step_fifo(input in_item_t it);
    logic [7:0]       emitted [$];
    logic [LEN_W-1:0] n;
    logic [CAP_W-1:0] cap_eff;
    logic [9:0]       p;
    logic             accepted;
    out_item_t        r;
    n        = (it.length > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : it.length;
    cap_eff  = (capacity_reg > STORE_DEPTH) ? CAP_W'(STORE_DEPTH) : capacity_reg;
    accepted = 1'b0;
    case (it.action)
      ACT_WRITE: begin
        if (fill_level < cap_eff) begin
          fifo_bytes[tail_idx] = it.data_byte;
          tail_idx       = tail_idx + 1'b1;
          fill_level     = fill_level + 1'b1;
          bytes_in_total = bytes_in_total + 1'b1;
          accepted       = 1'b1;
        end
      end
      ACT_END: stream_closed = 1'b1;
      ACT_PEEK: begin
        p = head_idx;
        for (int i = 0; i < n && i < fill_level; i++) begin
          emitted.push_back(fifo_bytes[p]);
          p = p + 1'b1;
        end
      end
      ACT_POP: begin
        // Over-long pop drains what is held and flags the error
        if (n > fill_level) begin
          error_seen = 1'b1;
          n = LEN_W'(fill_level);
        end
        head_idx        = head_idx + n;
        fill_level      = fill_level - n;
        bytes_out_total = bytes_out_total + n;
      end
      ACT_READ: begin
        // Over-long read removes nothing
        if (n > fill_level) begin
          error_seen = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            emitted.push_back(fifo_bytes[head_idx]);
            head_idx = head_idx + 1'b1;
          end
          fill_level      = fill_level - n;
          bytes_out_total = bytes_out_total + n;
        end
      end
      default: ;
    endcase
    r                = '0;
    r.error_flag     = error_seen;
    r.buffered_count = fill_level;
    r.total_written  = bytes_in_total;
    r.total_read     = bytes_out_total;
    r.ended_flag     = stream_closed;
    r.end_of_stream  = stream_closed && (fill_level == 0);
    if (emitted.size() == 0) begin
      r.last_of_run    = 1'b1;
      r.write_accepted = accepted;
      pending_results.push_back(r);
    end else begin
      foreach (emitted[i]) begin
        r.byte_out    = emitted[i];
        r.byte_valid  = 1'b1;
        r.last_of_run = (i == emitted.size() - 1);
        pending_results.push_back(r);
      end
    end
  endfunction

  function automatic directed_row_t pred_row(input logic [2:0] a, input logic [7:0] d,
                                             input logic [LEN_W-1:0] l);
    directed_row_t row;
    row.item  = '{action: a, data_byte: d, length: l};
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // Row with a single status result written out by hand
  function automatic directed_row_t typed_row(input logic [2:0] a, input logic [7:0] d,
                                              input logic [LEN_W-1:0] l, input logic acc,
                                              input logic err, input logic [CAP_W-1:0] cnt,
                                              input logic [TOTAL_W-1:0] tw,
                                              input logic [TOTAL_W-1:0] tr,
                                              input logic ended, input logic eos);
    directed_row_t row;
    row       = pred_row(a, d, l);
    row.typed = 1'b1;
    row.want  = '{byte_out: 8'h00, byte_valid: 1'b0, last_of_run: 1'b1,
                  write_accepted: acc, error_flag: err, buffered_count: cnt,
                  total_written: tw, total_read: tr, ended_flag: ended,
                  end_of_stream: eos};
    return row;
  endfunction

  // Mostly well-formed lengths, with some over-long and saturating ones
  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    int       lim;
    r            = $urandom_range(0, 99);
    lim          = (fill_level < MAX_LENGTH) ? int'(fill_level) + 1 : MAX_LENGTH;
    it.data_byte = 8'($urandom_range(0, 255));
    it.length    = ($urandom_range(0, 99) < 80) ? LEN_W'($urandom_range(0, lim))
                                                : LEN_W'($urandom_range(0, 127));
    if (r < 45)      it.action = ACT_WRITE;
    else if (r < 48) it.action = ACT_END;
    else if (r < 65) it.action = ACT_PEEK;
    else if (r < 80) it.action = ACT_READ;
    else if (r < 92) it.action = ACT_POP;
    else             it.action = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
    return it;
  endfunction

  // Offer one item, hold it until the transfer, then predict
  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t want = '0);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    step_fifo(it);
    if (typed) pending_results[pending_results.size() - 1] = want;
  endtask

  task automatic send_random_items(input int count);
    repeat (count) send_item(random_item());
  endtask

  // Drop push and wait for every expected result
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    capacity_reg = value;
  endtask

  task automatic compare_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("result with nothing expected: 0x%0h", got);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      compare_field("byte_out",       want.byte_out,       got.byte_out);
      compare_field("byte_valid",     want.byte_valid,     got.byte_valid);
      compare_field("last_of_run",    want.last_of_run,    got.last_of_run);
      compare_field("write_accepted", want.write_accepted, got.write_accepted);
      compare_field("error_flag",     want.error_flag,     got.error_flag);
      compare_field("buffered_count", want.buffered_count, got.buffered_count);
      compare_field("total_written",  want.total_written,  got.total_written);
      compare_field("total_read",     want.total_read,     got.total_read);
      compare_field("ended_flag",     want.ended_flag,     got.ended_flag);
      compare_field("end_of_stream",  want.end_of_stream,  got.end_of_stream);
    end
  endtask

  // Result side: check each transfer, then pick pop for the next cycle
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) check_result(out_item_o);
      if (long_hold_armed && !long_hold_taken) begin
        hold_left       = LONG_HOLD;
        long_hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: empty buffer, errors, saturation, end of input
    directed_rows.push_back(typed_row(ACT_PEEK,    8'h00, 7'd5,   0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(typed_row(ACT_READ,    8'h00, 7'd1,   0, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(typed_row(ACT_POP,     8'h00, 7'd0,   0, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(typed_row(ACT_WRITE,   8'h00, 7'd0,   1, 1, 1, 1, 0, 0, 0));
    directed_rows.push_back(typed_row(ACT_WRITE,   8'hFF, 7'd0,   1, 1, 2, 2, 0, 0, 0));
    directed_rows.push_back(typed_row(ACT_WRITE,   8'hA5, 7'd0,   1, 1, 3, 3, 0, 0, 0));
    directed_rows.push_back(typed_row(ACT_PEEK,    8'h00, 7'd0,   0, 1, 3, 3, 0, 0, 0));
    directed_rows.push_back(pred_row(ACT_PEEK,     8'h00, 7'd2));
    directed_rows.push_back(pred_row(ACT_PEEK,     8'h00, 7'd127));
    directed_rows.push_back(pred_row(ACT_READ,     8'h00, 7'd1));
    directed_rows.push_back(typed_row(ACT_END,     8'h00, 7'd0,   0, 1, 2, 3, 1, 1, 0));
    directed_rows.push_back(typed_row(ACT_WRITE,   8'h5A, 7'd0,   1, 1, 3, 4, 1, 1, 0));
    directed_rows.push_back(typed_row(ACT_POP,     8'h00, 7'd1,   0, 1, 2, 4, 2, 1, 0));
    directed_rows.push_back(typed_row(ACT_POP,     8'h00, 7'd127, 0, 1, 0, 4, 4, 1, 1));
    directed_rows.push_back(typed_row(ACT_RSVD_LO, 8'hFF, 7'd64,  0, 1, 0, 4, 4, 1, 1));
    directed_rows.push_back(typed_row(ACT_RSVD_HI, 8'h00, 7'd3,   0, 1, 0, 4, 4, 1, 1));
    directed_rows.push_back(typed_row(ACT_READ,    8'h00, 7'd0,   0, 1, 0, 4, 4, 1, 1));
    directed_rows.push_back(typed_row(ACT_WRITE,   8'hC3, 7'd127, 1, 1, 1, 5, 4, 1, 0));
    directed_rows.push_back(typed_row(ACT_READ,    8'h00, 7'd127, 0, 1, 1, 5, 4, 1, 0));
    directed_rows.push_back(pred_row(ACT_READ,     8'hFF, 7'd1));

    // Sender rarely idles, receiver idles often
    send_idle_pct = 6;
    recv_idle_pct = 56;
    set_capacity(CAP_RESET);
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    // Capacity of one byte
    set_capacity(11'd1);
    send_random_items(15);
    wait_drained();

    // Register above the store depth, idling swapped
    send_idle_pct = 56;
    recv_idle_pct = 6;
    set_capacity(11'h7FF);
    send_random_items(15);
    wait_drained();

    // No idling; hold off the receiver while a write burst backs up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_capacity(CAP_W'($urandom_range(100, 300)));
    send_item('{action: ACT_POP, data_byte: 8'h00, length: 7'd127});
    long_hold_armed = 1'b1;
    repeat (30)
      send_item('{action: ACT_WRITE, data_byte: 8'($urandom_range(0, 255)), length: 7'd0});
    send_item('{action: ACT_READ, data_byte: 8'h00, length: 7'd24});
    send_item('{action: ACT_PEEK, data_byte: 8'h00, length: 7'd127});
    send_random_items(10);
    wait_drained();

    // Zero capacity refuses every write
    set_capacity(11'd0);
    send_random_items(8);
    wait_drained();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
